@@ rtl/mdp_pkg.sv @@
// ----------------------------------------------------------------------------
// mdp_pkg
// Shared types, constants and helpers of the MIDI drum track event parser.
// ----------------------------------------------------------------------------
package mdp_pkg;

    // Width of the saturating tick total
    localparam int TICK_BITS = 32;

    localparam int TPQ_W       = 15;
    localparam int BYTE_W      = 8;
    localparam int DELTA_W     = 32;
    localparam int HIT_TICKS_W = 32;
    localparam int US_W        = 52;
    localparam int DRUM_W      = 4;

    // 600000 us per tick numerator (60e6 us per minute / 100 BPM)
    localparam int US_NUM_W = 20;
    localparam logic [US_NUM_W-1:0] US_PER_TICK_NUM = US_NUM_W'(600000);

    // Product of ticks and the numerator, dividend of the time divider
    localparam int PROD_W = TICK_BITS + US_NUM_W;
    localparam int CNT_W  = $clog2(PROD_W);
    localparam int REM_W  = TPQ_W + 1;

    // Adder width for delta accumulation
    localparam int SUM_W = ((TICK_BITS > DELTA_W) ? TICK_BITS : DELTA_W) + 1;
    localparam logic [SUM_W-1:0] TICK_MAX = (SUM_W'(1) << TICK_BITS) - SUM_W'(1);

    localparam logic [TPQ_W-1:0] TPQ_RESET = TPQ_W'(480);

    // Recognized status bytes
    localparam logic [BYTE_W-1:0] ST_BYTE_META = 8'hFF;
    localparam logic [BYTE_W-1:0] ST_BYTE_CC   = 8'hB9;
    localparam logic [BYTE_W-1:0] ST_BYTE_PC   = 8'hC9;
    localparam logic [BYTE_W-1:0] ST_BYTE_NOTE = 8'h99;

    typedef enum logic [2:0] {
        RS_NONE = 3'd0,
        RS_META = 3'd1,
        RS_CC   = 3'd2,
        RS_PC   = 3'd3,
        RS_NOTE = 3'd4
    } run_status_t;

    // One queued hit
    typedef struct packed {
        logic [TICK_BITS-1:0] ticks;
        logic [BYTE_W-1:0]    note;
        logic [DRUM_W-1:0]    drum;
    } hit_entry_t;

    // Queue status toward front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [DRUM_W-1:0] drum_map(input logic [BYTE_W-1:0] note);
        logic [DRUM_W-1:0] code;
        begin
            case (note)
                8'd38:   code = 4'd1;
                8'd41:   code = 4'd2;
                8'd47:   code = 4'd3;
                8'd45:   code = 4'd4;
                8'd42:   code = 4'd5;
                8'd51:   code = 4'd6;
                8'd49:   code = 4'd7;
                8'd36:   code = 4'd10;
                8'd46:   code = 4'd11;
                default: code = 4'd0;
            endcase
            return code;
        end
    endfunction

endpackage

@@ rtl/mdp_ifs.sv @@
// ----------------------------------------------------------------------------
// mdp interfaces
// Valid/ready channels for track bytes, configuration and hit words.
// ----------------------------------------------------------------------------
interface mdp_byte_if;
    import mdp_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] stream_byte;
    modport source (output valid, output stream_byte, input ready);
    modport sink   (input valid, input stream_byte, output ready);
endinterface

interface mdp_cfg_if;
    import mdp_pkg::*;
    logic             valid;
    logic             ready;
    logic [TPQ_W-1:0] ticks_per_quarter;
    modport source (output valid, output ticks_per_quarter, input ready);
    modport sink   (input valid, input ticks_per_quarter, output ready);
endinterface

interface mdp_hit_if;
    import mdp_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [HIT_TICKS_W-1:0] hit_ticks;
    logic [US_W-1:0]        hit_time_us;
    logic [BYTE_W-1:0]      note_number;
    logic [DRUM_W-1:0]      drum_code;
    modport source (output valid, output hit_ticks, output hit_time_us,
                    output note_number, output drum_code, input ready);
    modport sink   (input valid, input hit_ticks, input hit_time_us,
                    input note_number, input drum_code, output ready);
endinterface

@@ rtl/mdp_front.sv @@
// ----------------------------------------------------------------------------
// mdp_front
// Byte parser: delta times, running status, event skipping, hit capture.
// ----------------------------------------------------------------------------
module mdp_front (
    input  logic                clk,
    input  logic                rst_n,
    mdp_byte_if.sink            stream,
    input  mdp_pkg::q_stat_t    q_stat,
    output logic                push,
    output mdp_pkg::hit_entry_t push_entry
);
    import mdp_pkg::*;

    typedef enum logic [9:0] {
        PH_DELTA     = 10'b0000000001,
        PH_STATUS    = 10'b0000000010,
        PH_META_TYPE = 10'b0000000100,
        PH_META_LEN  = 10'b0000001000,
        PH_META_SKIP = 10'b0000010000,
        PH_CC_CTRL   = 10'b0000100000,
        PH_CC_VALUE  = 10'b0001000000,
        PH_PC_PROG   = 10'b0010000000,
        PH_NOTE_KEY  = 10'b0100000000,
        PH_NOTE_VEL  = 10'b1000000000
    } phase_t;

    phase_t               phase_reg, phase_next;
    run_status_t          rs_reg, rs_next;
    logic [DELTA_W-1:0]   delta_reg, delta_next;
    logic [TICK_BITS-1:0] tick_reg, tick_next;
    logic [BYTE_W-1:0]    skip_reg, skip_next;
    logic [BYTE_W-1:0]    key_reg, key_next;

    logic                 accept;
    logic [BYTE_W-1:0]    b;
    logic [BYTE_W-1:0]    skip_dec;
    logic [DELTA_W-1:0]   dv_sat;
    logic [SUM_W-1:0]     tick_sum;
    logic [TICK_BITS-1:0] tick_sat;
    phase_t               delta_phase;
    logic [DELTA_W-1:0]   delta_after;
    logic [TICK_BITS-1:0] tick_after;

    assign stream.ready = !q_stat.full;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.stream_byte;
    assign skip_dec     = skip_reg - BYTE_W'(1);

    // Delta byte: shift in seven bits, saturate once set bits would be lost
    always_comb
    begin
        if (delta_reg[DELTA_W-1 -: 7] != 7'd0)
            dv_sat = '1;
        else
            dv_sat = {delta_reg[DELTA_W-8:0], b[6:0]};
        tick_sum = SUM_W'(tick_reg) + SUM_W'(dv_sat);
        tick_sat = (tick_sum > TICK_MAX) ? TICK_MAX[TICK_BITS-1:0]
                                         : tick_sum[TICK_BITS-1:0];
        if (b[7])
        begin
            delta_phase = PH_DELTA;
            delta_after = dv_sat;
            tick_after  = tick_reg;
        end
        else
        begin
            delta_phase = PH_STATUS;
            delta_after = '0;
            tick_after  = tick_sat;
        end
    end

    always_comb
    begin
        phase_next = phase_reg;
        rs_next    = rs_reg;
        delta_next = delta_reg;
        tick_next  = tick_reg;
        skip_next  = skip_reg;
        key_next   = key_reg;
        push       = 1'b0;
        push_entry = '{ticks: tick_reg, note: key_reg, drum: drum_map(key_reg)};
        if (accept)
        begin
            case (phase_reg)
                PH_DELTA:
                begin
                    phase_next = delta_phase;
                    delta_next = delta_after;
                    tick_next  = tick_after;
                end
                PH_STATUS:
                begin
                    if (b == ST_BYTE_META)
                    begin
                        rs_next    = RS_META;
                        phase_next = PH_META_TYPE;
                    end
                    else if (b == ST_BYTE_CC)
                    begin
                        rs_next    = RS_CC;
                        phase_next = PH_CC_CTRL;
                    end
                    else if (b == ST_BYTE_PC)
                    begin
                        rs_next    = RS_PC;
                        phase_next = PH_PC_PROG;
                    end
                    else if (b == ST_BYTE_NOTE)
                    begin
                        rs_next    = RS_NOTE;
                        phase_next = PH_NOTE_KEY;
                    end
                    else
                    begin
                        // Take the byte as first data of the running event
                        case (rs_reg)
                            RS_META: phase_next = PH_META_LEN;
                            RS_CC:   phase_next = PH_CC_VALUE;
                            RS_PC:   phase_next = PH_DELTA;
                            RS_NOTE:
                            begin
                                key_next   = b;
                                phase_next = PH_NOTE_VEL;
                            end
                            default:
                            begin
                                // No running status: restart delta decoding
                                phase_next = delta_phase;
                                delta_next = delta_after;
                                tick_next  = tick_after;
                            end
                        endcase
                    end
                end
                PH_META_TYPE: phase_next = PH_META_LEN;
                PH_META_LEN:
                begin
                    skip_next  = b;
                    phase_next = (b == '0) ? PH_DELTA : PH_META_SKIP;
                end
                PH_META_SKIP:
                begin
                    skip_next = skip_dec;
                    if (skip_dec == '0)
                        phase_next = PH_DELTA;
                end
                PH_CC_CTRL:  phase_next = PH_CC_VALUE;
                PH_CC_VALUE: phase_next = PH_DELTA;
                PH_PC_PROG:  phase_next = PH_DELTA;
                PH_NOTE_KEY:
                begin
                    key_next   = b;
                    phase_next = PH_NOTE_VEL;
                end
                PH_NOTE_VEL:
                begin
                    phase_next = PH_DELTA;
                    if (b != '0)
                    begin
                        push      = 1'b1;
                        tick_next = '0;
                    end
                end
                default:
                begin
                    phase_next = delta_phase;
                    delta_next = delta_after;
                    tick_next  = tick_after;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_DELTA;
            rs_reg    <= RS_NONE;
            delta_reg <= '0;
            tick_reg  <= '0;
            skip_reg  <= '0;
            key_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            rs_reg    <= rs_next;
            delta_reg <= delta_next;
            tick_reg  <= tick_next;
            skip_reg  <= skip_next;
            key_reg   <= key_next;
        end
    end

endmodule

@@ rtl/mdp_queue.sv @@
// ----------------------------------------------------------------------------
// mdp_queue
// Two-entry hit queue between parser and time converter.
// ----------------------------------------------------------------------------
module mdp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  mdp_pkg::hit_entry_t push_entry,
    input  logic                pop,
    output mdp_pkg::hit_entry_t pop_entry,
    output mdp_pkg::q_stat_t    q_stat
);
    import mdp_pkg::*;

    hit_entry_t  mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    assign pop_entry    = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ rtl/mdp_back.sv @@
// ----------------------------------------------------------------------------
// mdp_back
// Time converter: ticks*600000 then bit-serial divide by ticks per quarter.
// ----------------------------------------------------------------------------
module mdp_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [mdp_pkg::TPQ_W-1:0]   tpq,
    input  mdp_pkg::q_stat_t            q_stat,
    input  mdp_pkg::hit_entry_t         pop_entry,
    output logic                        pop,
    mdp_hit_if.source                   hits
);
    import mdp_pkg::*;

    typedef enum logic [3:0] {
        BK_IDLE = 4'b0001,
        BK_MUL  = 4'b0010,
        BK_DIV  = 4'b0100,
        BK_OUT  = 4'b1000
    } bk_state_t;

    bk_state_t         state_reg, state_next;
    hit_entry_t        ent_reg;
    logic [PROD_W-1:0] dvd_reg;
    logic [TPQ_W-1:0]  rem_reg;
    logic [CNT_W-1:0]  cnt_reg;

    logic [TPQ_W-1:0]  divisor;
    logic [REM_W-1:0]  rem_shift;
    logic              ge;
    logic [REM_W-1:0]  rem_sub;

    // Zero ticks per quarter acts as one
    assign divisor   = (tpq == '0) ? TPQ_W'(1) : tpq;
    assign rem_shift = {rem_reg, dvd_reg[PROD_W-1]};
    assign ge        = (rem_shift >= REM_W'(divisor));
    assign rem_sub   = rem_shift - REM_W'(divisor);
    assign pop       = (state_reg == BK_IDLE) && !q_stat.empty;

    assign hits.valid       = (state_reg == BK_OUT);
    assign hits.hit_ticks   = HIT_TICKS_W'(ent_reg.ticks);
    assign hits.hit_time_us = US_W'(dvd_reg);
    assign hits.note_number = ent_reg.note;
    assign hits.drum_code   = ent_reg.drum;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (!q_stat.empty) state_next = BK_MUL;
            BK_MUL:  state_next = BK_DIV;
            BK_DIV:  if (cnt_reg == '0) state_next = BK_OUT;
            BK_OUT:  if (hits.ready) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_stat.empty)
                    ent_reg <= pop_entry;
            end
            BK_MUL:
            begin
                dvd_reg <= PROD_W'(ent_reg.ticks) * PROD_W'(US_PER_TICK_NUM);
                rem_reg <= '0;
                cnt_reg <= CNT_W'(PROD_W - 1);
            end
            BK_DIV:
            begin
                // Restoring step: one quotient bit per cycle
                rem_reg <= ge ? rem_sub[TPQ_W-1:0] : rem_shift[TPQ_W-1:0];
                dvd_reg <= {dvd_reg[PROD_W-2:0], ge};
                cnt_reg <= cnt_reg - CNT_W'(1);
            end
            default:
            begin
                // Hold the finished word
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

@@ rtl/midi_drum_track_event_parser_unit.sv @@
// ----------------------------------------------------------------------------
// midi_drum_track_event_parser_unit
// MIDI drum track parser: delta times, running status, note-on hit words.
// ----------------------------------------------------------------------------
// Throughput: one track byte per cycle while the hit queue has room.
// A hit word follows the velocity byte through the hit queue, the multiply
//   and the one-bit-per-cycle time divider.
// The divider works on one hit at a time; two more hits wait in
//   the queue before the byte input stalls.
// Reset: asynchronous, active low; parser goes to delta decoding with no
//   running status, queue empties, ticks per quarter returns to 480.
module midi_drum_track_event_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    mdp_byte_if.sink   stream,
    mdp_cfg_if.sink    cfg,
    mdp_hit_if.source  hits
);
    import mdp_pkg::*;

    // Ticks per quarter register; the user must write it only while the block is idle (not enforced here)
    logic [TPQ_W-1:0] tpq_reg;

    hit_entry_t push_entry;
    hit_entry_t pop_entry;
    q_stat_t    q_stat;
    logic       push;
    logic       pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tpq_reg <= TPQ_RESET;
        else if (cfg.valid)
            tpq_reg <= cfg.ticks_per_quarter;
    end

    // Front: classify each byte, accumulate ticks, capture note-on hits
    mdp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .stream     (stream),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    // Queue: decouple byte parsing from the slow time conversion
    mdp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .q_stat     (q_stat)
    );

    // Back: convert ticks to microseconds and hold the hit word
    mdp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tpq       (tpq_reg),
        .q_stat    (q_stat),
        .pop_entry (pop_entry),
        .pop       (pop),
        .hits      (hits)
    );

endmodule

@@ rtl/mdp_checker.sv @@
// ----------------------------------------------------------------------------
// mdp_checker
// Port-level checks of the drum track parser, bound to the top level.
// ----------------------------------------------------------------------------
module mdp_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            hit_valid,
    input logic                            hit_ready,
    input logic [mdp_pkg::HIT_TICKS_W-1:0] hit_ticks,
    input logic [mdp_pkg::US_W-1:0]        hit_time_us,
    input logic [mdp_pkg::BYTE_W-1:0]      note_number,
    input logic [mdp_pkg::DRUM_W-1:0]      drum_code
);
    import mdp_pkg::*;

    // Hold a stalled hit word
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && !hit_ready |=> hit_valid && $stable(hit_ticks)
            && $stable(hit_time_us) && $stable(note_number) && $stable(drum_code))
        else $error("hit word changed while stalled");

    a_drum_range: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> drum_code <= DRUM_W'(11))
        else $error("drum code out of range");

    a_drum_map: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid |-> drum_code == drum_map(note_number))
        else $error("drum code does not match note");

    a_zero_time: assert property (@(posedge clk) disable iff (!rst_n)
        hit_valid && hit_ticks == '0 |-> hit_time_us == '0)
        else $error("nonzero time for zero ticks");

endmodule

bind midi_drum_track_event_parser_unit mdp_checker u_mdp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .hit_valid   (hits.valid),
    .hit_ready   (hits.ready),
    .hit_ticks   (hits.hit_ticks),
    .hit_time_us (hits.hit_time_us),
    .note_number (hits.note_number),
    .drum_code   (hits.drum_code)
);
